// ===== hw/rtl/lne_pkg.sv =====
package lne_pkg;

    localparam int VALUE_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int FUNC_W  = 2;
    localparam int VALUE_W = 16;
    localparam int ROW_W   = 2;
    localparam int COL_W   = 6;
    localparam int IN_BITS = FUNC_W + VALUE_W + ROW_W + COL_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_DATA   = 2'd0,
        FUNC_CMD    = 2'd1,
        FUNC_NUMBER = 2'd2,
        FUNC_CURSOR = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE    = 2'd0,
        REG_SELECT    = 2'd1,
        REG_BACKLIGHT = 2'd2
    } reg_idx_t;

    localparam logic [7:0] ENABLE_RESET    = 8'h04;
    localparam logic [7:0] SELECT_RESET    = 8'h01;
    localparam logic [7:0] BACKLIGHT_RESET = 8'h08;

    localparam logic [7:0] SET_DDRAM_CMD = 8'h80;
    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

    // Expander bit masks used by the byte sequencer
    typedef struct packed {
        logic [7:0] enable;
        logic [7:0] select;
        logic [7:0] backlight;
    } cfg_t;

    // One LCD byte waiting to be strobed out as six expander bytes
    typedef struct packed {
        logic [7:0] lcd_byte;
        logic       is_data;
        logic       last;
    } entry_t;

    function automatic logic [7:0] row_base(input logic [ROW_W-1:0] row);
        logic [7:0] base;
        case (row)
            2'd0:    base = 8'h00;
            2'd1:    base = 8'h40;
            2'd2:    base = 8'h14;
            2'd3:    base = 8'h54;
            default: base = 8'h00;
        endcase
        return base;
    endfunction

    function automatic logic [7:0] cursor_cmd(input logic [ROW_W-1:0] row,
                                              input logic [COL_W-1:0] col);
        logic [7:0] addr;
        addr = {{(8-COL_W){1'b0}}, col} + row_base(row);
        return SET_DDRAM_CMD | addr;
    endfunction

endpackage

// ===== hw/rtl/lne_queue.sv =====
module lne_queue #(
    parameter int DEPTH = lne_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lne_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output lne_pkg::entry_t head,
    output logic            empty
);
    import lne_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/lne_front.sv =====
module lne_front #(
    parameter int VALUE_WIDTH = lne_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lne_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           q_push,
    output lne_pkg::entry_t                q_entry,
    input  logic                           q_full
);
    import lne_pkg::*;

    // Decimal digits needed for the widest number (log10(2) ~ 1233/4096)
    localparam int DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int BCD_W  = DIGITS * 4;
    localparam int DIG_W  = $clog2(DIGITS);
    localparam int CNT_W  = $clog2(VALUE_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [DIG_W-1:0]       dig_reg, dig_next;
    logic [7:0]             byte_reg, byte_next;
    logic                   data_reg, data_next;
    logic                   num_reg, num_next;

    func_t            in_func;
    logic [VALUE_W-1:0] in_value;
    logic [ROW_W-1:0] in_row;
    logic [COL_W-1:0] in_col;
    logic             accept;
    logic [BCD_W-1:0] bcd_adj;
    logic [BCD_W-1:0] bcd_shift;
    logic [DIG_W-1:0] lead_idx;
    logic [3:0]       cur_digit;

    assign in_func  = func_t'(s_tdata[FUNC_W-1:0]);
    assign in_value = s_tdata[FUNC_W +: VALUE_W];
    assign in_row   = s_tdata[FUNC_W+VALUE_W +: ROW_W];
    assign in_col   = s_tdata[FUNC_W+VALUE_W+ROW_W +: COL_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Shift-and-add-3 step: bump every digit that would overflow on doubling
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    assign bcd_shift = {bcd_adj[BCD_W-2:0], val_reg[VALUE_WIDTH-1]};

    // Most significant nonzero digit of the finished conversion; zero prints one digit
    always_comb
    begin
        lead_idx = '0;
        for (int i = 1; i < DIGITS; i++)
        begin
            if (bcd_shift[i*4 +: 4] != 4'd0)
            begin
                lead_idx = DIG_W'(i);
            end
        end
    end

    assign cur_digit = bcd_reg[dig_reg*4 +: 4];

    always_comb
    begin
        q_push = 1'b0;
        if (num_reg)
        begin
            q_entry.lcd_byte = {ASCII_DIGIT_HI, cur_digit};
            q_entry.is_data  = 1'b1;
            q_entry.last     = (dig_reg == '0);
        end
        else
        begin
            q_entry.lcd_byte = byte_reg;
            q_entry.is_data  = data_reg;
            q_entry.last     = 1'b1;
        end
        if ((state_reg == ST_EMIT) && !q_full)
        begin
            q_push = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        val_next   = val_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        dig_next   = dig_reg;
        byte_next  = byte_reg;
        data_next  = data_reg;
        num_next   = num_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    num_next  = 1'b0;
                    data_next = (in_func == FUNC_DATA);
                    case (in_func)
                        FUNC_DATA, FUNC_CMD:
                        begin
                            byte_next  = in_value[7:0];
                            state_next = ST_EMIT;
                        end
                        FUNC_CURSOR:
                        begin
                            byte_next  = cursor_cmd(in_row, in_col);
                            state_next = ST_EMIT;
                        end
                        FUNC_NUMBER:
                        begin
                            num_next   = 1'b1;
                            val_next   = in_value[VALUE_WIDTH-1:0];
                            bcd_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_CONV;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                bcd_next = bcd_shift;
                val_next = {val_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    dig_next   = lead_idx;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (q_push)
                begin
                    if (q_entry.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        dig_next = dig_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        dig_reg  <= dig_next;
        byte_reg <= byte_next;
        data_reg <= data_next;
        num_reg  <= num_next;
    end

endmodule

// ===== hw/rtl/lne_back.sv =====
module lne_back (
    input  logic            clk,
    input  logic            rst_n,
    input  lne_pkg::cfg_t   cfg,
    input  lne_pkg::entry_t q_head,
    input  logic            q_empty,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,   // [7:0] expander_byte
    output logic            m_tlast
);
    import lne_pkg::*;

    localparam logic [1:0] PH_PLAIN  = 2'd0;
    localparam logic [1:0] PH_STROBE = 2'd1;
    localparam logic [1:0] PH_CLEAR  = 2'd2;

    entry_t     cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic       half_reg, half_next;
    logic [1:0] phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;

    logic       load;
    logic       last_step;
    logic [3:0] nibble;
    logic [7:0] mode;
    logic [7:0] plain;
    logic [7:0] exp_byte;

    assign load      = cur_valid_reg && (!out_valid_reg || m_tready);
    assign last_step = half_reg && (phase_reg == PH_CLEAR);
    assign q_pop     = !q_empty && (!cur_valid_reg || (load && last_step));

    assign nibble = half_reg ? cur_reg.lcd_byte[3:0] : cur_reg.lcd_byte[7:4];
    assign mode   = cur_reg.is_data ? (cfg.select | cfg.backlight) : cfg.backlight;
    assign plain  = {nibble, 4'b0000} | mode;

    always_comb
    begin
        case (phase_reg)
            PH_PLAIN:  exp_byte = plain;
            PH_STROBE: exp_byte = plain | cfg.enable;
            PH_CLEAR:  exp_byte = plain & ~cfg.enable;
            default:   exp_byte = plain;
        endcase
    end

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        half_next      = half_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = exp_byte;
            out_last_next  = cur_reg.last && last_step;
            if (phase_reg == PH_CLEAR)
            begin
                phase_next = PH_PLAIN;
                half_next  = !half_reg;
            end
            else
            begin
                phase_next = phase_reg + 1'b1;
            end
            if (last_step)
            begin
                cur_valid_next = 1'b0;
            end
        end

        // Take the next LCD byte once the last expander byte of the current one is loaded for output
        if (q_pop)
        begin
            cur_next       = q_head;
            cur_valid_next = 1'b1;
            half_next      = 1'b0;
            phase_next     = PH_PLAIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
            phase_reg     <= PH_PLAIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            half_reg      <= half_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== hw/rtl/lcd_nibble_expander_encoder_core.sv =====
// Throughput: one expander byte per cycle while m_tready is high; each character, command or cursor
//   move is six expander bytes from the strobe sequencer; numbers give six per digit and also
//   wait on the front converter, which makes one queue push per digit.
// Path: input transaction, front state register, queue slot, current-byte register, output
//   register; numbers first pass the serial BCD converter.
// Reset (rst_n, async low): queue and output empty, masks back to 0x04 / 0x01 / 0x08.
module lcd_nibble_expander_encoder_core #(
    parameter int VALUE_WIDTH = lne_pkg::VALUE_WIDTH_DEF,
    parameter int QUEUE_DEPTH = lne_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lne_pkg::IN_DATA_W-1:0]     s_tdata,  // [1:0] func, [17:2] value,
                                                        // [19:18] row, [25:20] col
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,  // [7:0] expander_byte
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [lne_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lne_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lne_pkg::*;

    cfg_t   cfg_reg;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;
    entry_t q_in;
    entry_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable    <= ENABLE_RESET;
            cfg_reg.select    <= SELECT_RESET;
            cfg_reg.backlight <= BACKLIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_ENABLE:    cfg_reg.enable    <= cfg_data;
                REG_SELECT:    cfg_reg.select    <= cfg_data;
                REG_BACKLIGHT: cfg_reg.backlight <= cfg_data;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    lne_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_push   (q_push),
        .q_entry  (q_in),
        .q_full   (q_full)
    );

    lne_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    lne_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_head   (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== sim/lcd_nibble_expander_encoder_core_tb.sv =====
`timescale 1ns / 1ps

module lcd_nibble_expander_encoder_core_tb;

    import lne_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] exp_byte;
        logic       exp_last;
    } expander_byte_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Local copy of the expander masks, tracks every register write
    logic [7:0] enable_bits = ENABLE_RESET;
    logic [7:0] select_bits = SELECT_RESET;
    logic [7:0] backlight_bits = BACKLIGHT_RESET;

    expander_byte_t expander_bytes_due[$];
    expander_byte_t due;

    int  failures = 0;
    int  requests_seen = 0;
    int  bytes_checked = 0;
    int  mask_settings = 1;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  steady = 1'b0;

    lcd_nibble_expander_encoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Queue the six expander bytes of one LCD byte: high nibble, then low nibble
    function automatic void queue_lcd_byte(input logic [7:0] lcd, input logic [7:0] mode,
                                           input bit is_final);
        logic [7:0] nib [2];
        logic [7:0] plain;
        nib[0] = lcd & 8'hF0;
        nib[1] = {lcd[3:0], 4'h0};
        for (int i = 0; i < 2; i++)
        begin
            plain = nib[i] | mode;
            expander_bytes_due.push_back(expander_byte_t'{plain, 1'b0});
            expander_bytes_due.push_back(expander_byte_t'{plain | enable_bits, 1'b0});
            expander_bytes_due.push_back(expander_byte_t'{plain & ~enable_bits,
                                                          is_final && (i == 1)});
        end
    endfunction

    function automatic void predict_expander_bytes(input logic [IN_DATA_W-1:0] word);
        func_t       f;
        logic [15:0] v;
        logic [1:0]  r;
        logic [5:0]  c;
        logic [7:0]  data_mode;
        logic [7:0]  cmd_mode;
        logic [7:0]  base;
        logic [3:0]  digits [5];
        int          ndig;
        int unsigned rest;
        f = func_t'(word[1:0]);
        v = word[17:2];
        r = word[19:18];
        c = word[25:20];
        data_mode = select_bits | backlight_bits;
        cmd_mode = backlight_bits;
        case (f)
            FUNC_DATA:
                queue_lcd_byte(v[7:0], data_mode, 1'b1);
            FUNC_CMD:
                queue_lcd_byte(v[7:0], cmd_mode, 1'b1);
            FUNC_NUMBER:
            begin
                // Split into decimal digits, least significant first; zero is one digit
                rest = v;
                ndig = 0;
                do
                begin
                    digits[ndig] = 4'(rest % 10);
                    rest = rest / 10;
                    ndig++;
                end while (rest != 0);
                for (int i = ndig - 1; i >= 0; i--)
                    queue_lcd_byte({ASCII_DIGIT_HI, digits[i]}, data_mode, i == 0);
            end
            default:
            begin
                case (r)
                    2'd0:    base = 8'h00;
                    2'd1:    base = 8'h40;
                    2'd2:    base = 8'h14;
                    default: base = 8'h54;
                endcase
                queue_lcd_byte(SET_DDRAM_CMD | ({2'b00, c} + base), cmd_mode, 1'b1);
            end
        endcase
    endfunction

    // Predict on every input transaction, compare every output transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_expander_bytes(s_tdata);
                requests_seen++;
            end
            if (m_tvalid && m_tready)
            begin
                bytes_checked++;
                if (expander_bytes_due.size() == 0)
                begin
                    $error("unexpected transaction: expander_byte %02h last %0b",
                           m_tdata, m_tlast);
                    failures++;
                end
                else
                begin
                    due = expander_bytes_due.pop_front();
                    if (m_tdata !== due.exp_byte)
                    begin
                        $error("expander_byte mismatch: expected %02h, actual %02h",
                               due.exp_byte, m_tdata);
                        failures++;
                    end
                    if (m_tlast !== due.exp_last)
                    begin
                        $error("last mismatch: expected %0b, actual %0b",
                               due.exp_last, m_tlast);
                        failures++;
                    end
                end
            end
        end
    end

    // Receiver: drops ready in random stall bursts; always ready once steady is set
    always @(posedge clk)
    begin
        if (steady)
        begin
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_request(input func_t f, input logic [15:0] v,
                                input logic [1:0] r, input logic [5:0] c);
        if (!steady && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_DATA_W - IN_BITS){1'b0}}, c, r, v, f};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_random_request();
        func_t       f;
        logic [15:0] v;
        f = func_t'($urandom_range(0, 3));
        v = 16'($urandom_range(0, 65535));
        // Spread numbers over every digit count
        if (f == FUNC_NUMBER)
        begin
            case ($urandom_range(0, 5))
                0: v = 16'($urandom_range(0, 9));
                1: v = 16'($urandom_range(10, 99));
                2: v = 16'($urandom_range(100, 999));
                3: v = 16'($urandom_range(1000, 9999));
                default: v = 16'($urandom_range(10000, 65535));
            endcase
        end
        send_request(f, v, 2'($urandom_range(0, 3)),
                     6'(($urandom_range(0, 3) == 0) ? $urandom_range(40, 63)
                                                     : $urandom_range(0, 39)));
    endtask

    // Drop valid and hold until every expected byte has come out
    task automatic drain(input int extra);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expander_bytes_due.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_masks(input logic [7:0] en, input logic [7:0] sel,
                             input logic [7:0] bl);
        cfg_we <= 1'b1;
        cfg_index <= REG_ENABLE;
        cfg_data <= en;
        @(posedge clk);
        cfg_index <= REG_SELECT;
        cfg_data <= sel;
        @(posedge clk);
        cfg_index <= REG_BACKLIGHT;
        cfg_data <= bl;
        @(posedge clk);
        cfg_we <= 1'b0;
        enable_bits = en;
        select_bits = sel;
        backlight_bits = bl;
        mask_settings++;
    endtask

    task automatic test_characters_and_commands();
        send_request(FUNC_DATA, 16'h0000, 2'd0, 6'd0);
        send_request(FUNC_DATA, 16'h00FF, 2'd3, 6'd63);
        send_request(FUNC_DATA, 16'h0041, 2'd0, 6'd0);
        // Bits above the low byte are not sent
        send_request(FUNC_DATA, 16'hABCD, 2'd2, 6'd21);
        send_request(FUNC_CMD, 16'h0001, 2'd0, 6'd0);
        send_request(FUNC_CMD, 16'hFF00, 2'd1, 6'd42);
        send_request(FUNC_CMD, 16'hFFFF, 2'd3, 6'd63);
        drain(8);
    endtask

    task automatic test_decimal_numbers();
        send_request(FUNC_NUMBER, 16'd0, 2'd0, 6'd0);
        send_request(FUNC_NUMBER, 16'd9, 2'd0, 6'd0);
        send_request(FUNC_NUMBER, 16'd10, 2'd0, 6'd0);
        send_request(FUNC_NUMBER, 16'd99, 2'd0, 6'd0);
        send_request(FUNC_NUMBER, 16'd100, 2'd0, 6'd0);
        send_request(FUNC_NUMBER, 16'd9999, 2'd0, 6'd0);
        send_request(FUNC_NUMBER, 16'd10000, 2'd0, 6'd0);
        send_request(FUNC_NUMBER, 16'd65535, 2'd3, 6'd63);
        drain(8);
    endtask

    task automatic test_cursor_moves();
        send_request(FUNC_CURSOR, 16'h0000, 2'd0, 6'd0);
        send_request(FUNC_CURSOR, 16'hFFFF, 2'd1, 6'd0);
        send_request(FUNC_CURSOR, 16'h0000, 2'd2, 6'd0);
        send_request(FUNC_CURSOR, 16'h0000, 2'd3, 6'd0);
        send_request(FUNC_CURSOR, 16'h0000, 2'd3, 6'd39);
        // Column beyond the display is not clipped
        send_request(FUNC_CURSOR, 16'h0000, 2'd3, 6'd63);
        drain(8);
    endtask

    task automatic test_mask_settings();
        logic [7:0] settings [5][3];
        settings = '{'{8'h00, 8'h00, 8'h00},
                     '{8'hFF, 8'hFF, 8'hFF},
                     '{8'h04, 8'h04, 8'h04},
                     '{8'h02, 8'h01, 8'h08},
                     '{8'h00, 8'h00, 8'h00}};
        // Last slot gets random masks
        settings[4][0] = 8'($urandom_range(0, 255));
        settings[4][1] = 8'($urandom_range(0, 255));
        settings[4][2] = 8'($urandom_range(0, 255));
        for (int s = 0; s < 5; s++)
        begin
            set_masks(settings[s][0], settings[s][1], settings[s][2]);
            repeat (64) send_random_request();
            drain(8);
        end
    endtask

    task automatic test_back_to_back_traffic();
        set_masks(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
        steady = 1'b1;
        repeat (80) send_random_request();
        drain(20);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_characters_and_commands();
        test_decimal_numbers();
        test_cursor_moves();
        test_mask_settings();
        test_back_to_back_traffic();
        $display("Checked %0d expander bytes from %0d requests under %0d mask settings,",
                 bytes_checked, requests_seen, mask_settings);
        $display("covering characters, commands, numbers, cursor moves and stalls.");
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/lne_pkg.sv
hw/rtl/lne_queue.sv
hw/rtl/lne_front.sv
hw/rtl/lne_back.sv
hw/rtl/lcd_nibble_expander_encoder_core.sv
sim/lcd_nibble_expander_encoder_core_tb.sv
